/* hw/rtl/kce_pkg.sv */
// ---------------------------------------------------------------------------
// kce_pkg
// Types and constants shared by the k-means clustering engine.
// ---------------------------------------------------------------------------
`default_nettype none

package kce_pkg;

   localparam int MAX_CLUSTERS = 8;
   localparam int MAX_DIM      = 8;
   localparam int COORD_BITS   = 32;
   localparam int CSLOTS       = MAX_CLUSTERS * MAX_DIM;
   localparam int KBITS        = 3;
   localparam int DIM_BITS     = 3;
   localparam int CADDR_BITS   = 6;
   localparam int CLOAD_BITS   = 7;
   localparam int CFG_BITS     = 4;
   localparam int ITER_BITS    = 16;
   localparam int EPS_BITS     = 63;
   localparam int DIST_BITS    = 64;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [1:0] CMD_LOAD_POINT    = 2'd0;
   localparam logic [1:0] CMD_LOAD_CENTROID = 2'd1;
   localparam logic [1:0] CMD_START         = 2'd2;
   localparam logic [1:0] CMD_RESERVED      = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_NUM_CLUSTERS   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VECTOR_DIM     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ITERATIONS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EPSILON_SQ     = 2'd3;

   typedef struct packed {
      logic [1:0]                    cmd;
      logic signed [COORD_BITS-1:0]  coord_value;
   } req_type;

   typedef struct packed {
      logic [KBITS-1:0]              cluster_index;
      logic [DIM_BITS-1:0]           coord_index;
      logic signed [COORD_BITS-1:0]  centroid_value;
      logic                          converged;
      logic [ITER_BITS-1:0]          iterations_done;
      logic                          last;
   } rsp_type;

   // tag that travels with a squared distance term
   typedef struct packed {
      logic             vld;
      logic             last;
      logic             upd;
      logic [KBITS-1:0] kidx;
   } tag_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ITER_INIT,
      ST_ASN_ISSUE,
      ST_ASN_DRAIN,
      ST_ACC_ISSUE,
      ST_UPD_INIT,
      ST_UPD_RD,
      ST_UPD_LOAD,
      ST_UPD_DIV,
      ST_UPD_WR,
      ST_UPD_DRAIN,
      ST_ITER_END,
      ST_OUT_RD,
      ST_OUT_CAP
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/kmeans_clustering_engine.sv */
// ---------------------------------------------------------------------------
// kmeans_clustering_engine
// Lloyd k-means over loaded points and centroids, fixed point Q16.16.
// ---------------------------------------------------------------------------
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  request | req_valid  req_stall  req_data | load point/centroid word, start
//  result  | rsp_valid  rsp_stall  rsp_data | one final centroid coordinate
//  config  | csr_we  csr_index  csr_wdata   | register write, no read-back
//
//  a start runs, per iteration, assignment (memory port of the point store)
//  plus centroid update (bit-serial divider), then sends the result words.
//  reset is synchronous; sums clear through valid bits, counts as registers, no sweep.
//  req_stall is high for the whole run; a result word waits in its register.
// ---------------------------------------------------------------------------
`default_nettype none

module kmeans_clustering_engine #(
   parameter int MAX_POINTS = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire kce_pkg::req_type                      req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output kce_pkg::rsp_type                           rsp_data,
   input  wire logic                                  csr_we,
   input  wire logic [kce_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [kce_pkg::EPS_BITS-1:0]          csr_wdata
);
   import kce_pkg::*;

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int PCW    = $clog2(MAX_POINTS + 1);
   localparam int PAW    = PW + DIM_BITS;
   localparam int PDEPTH = MAX_POINTS * MAX_DIM;
   localparam int SUMW   = COORD_BITS + PW;
   localparam int DCW    = $clog2(SUMW);

   function automatic logic [CFG_BITS-1:0] clamp_sel(input logic [CFG_BITS-1:0] v);
      logic [CFG_BITS-1:0] r;
      r = v;
      if (v == '0) r = CFG_BITS'(1);
      else if (v > CFG_BITS'(8)) r = CFG_BITS'(8);
      return r;
   endfunction

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] d;
      logic [COORD_BITS:0] m;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      m = d[COORD_BITS] ? (~d + 1'b1) : d;
      return m[COORD_BITS-1:0];
   endfunction

   // memories
   logic [COORD_BITS-1:0] point_mem [PDEPTH];
   logic [COORD_BITS-1:0] cent_mem  [CSLOTS];
   logic [SUMW-1:0]       sum_mem   [CSLOTS];

   // configuration
   logic [CFG_BITS-1:0]  ncl_ff, vdim_ff;
   logic [ITER_BITS-1:0] maxit_ff;
   logic [EPS_BITS-1:0]  eps_ff;

   // control
   state_type             state_ff, state_in;
   logic [PCW-1:0]        npts_ff, npts_in;
   logic [DIM_BITS-1:0]   ppos_ff, ppos_in;
   logic [CLOAD_BITS-1:0] cload_ff, cload_in;
   logic [CFG_BITS-1:0]   kuse_ff, kuse_in, duse_ff, duse_in;
   logic [PW-1:0]         p_ff, p_in;
   logic [KBITS-1:0]      k_ff, k_in;
   logic [DIM_BITS-1:0]   j_ff, j_in;
   logic [CADDR_BITS-1:0] caddr_ff, caddr_in, sbase_ff, sbase_in;
   logic [ITER_BITS-1:0]  iter_ff, iter_in;
   logic                  conv_ok_ff, conv_ok_in, conv_out_ff, conv_out_in;
   tag_type               s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic                  ac_vld_ff, ac_vld_in;
   logic [CADDR_BITS-1:0] ac_addr_ff, ac_addr_in;
   logic [CSLOTS-1:0]     sumv_ff, sumv_in;
   logic [PCW-1:0]        count_ff [MAX_CLUSTERS];
   logic [PCW-1:0]        count_in [MAX_CLUSTERS];
   logic [DCW-1:0]        dcnt_ff, dcnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [COORD_BITS-1:0] pt_rd_ff, ct_rd_ff, old_ff, old_in;
   logic [SUMW-1:0]       sum_rd_ff;
   logic [COORD_BITS-1:0] absd_ff, absd_in;
   logic [DIST_BITS-1:0]  prod_ff, prod_in, dist_ff, dist_in, bestd_ff, bestd_in;
   logic [KBITS-1:0]      bestk_ff, bestk_in;
   logic [PCW:0]          drem_ff, drem_in;
   logic [SUMW-1:0]       dquo_ff, dquo_in;
   logic                  dneg_ff, dneg_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // memory ports
   logic                  pt_we, cent_we, sum_we;
   logic [PAW-1:0]        pt_waddr, pt_raddr;
   logic [COORD_BITS-1:0] pt_wdata, cent_wdata;
   logic [CADDR_BITS-1:0] cent_waddr, sum_waddr, sum_raddr;
   logic [SUMW-1:0]       sum_wdata;

   // helpers
   logic                  req_acc, out_free, j_last, k_last, p_last, pipe_empty;
   logic [PCW-1:0]        count_k;
   logic [CFG_BITS-1:0]   dcur;
   logic [DIST_BITS:0]    dsum;
   logic [DIST_BITS-1:0]  dsat;
   logic [SUMW-1:0]       sum_cur, sum_mag, pt_ext;
   logic [PCW:0]          dtry;
   logic                  dge;
   logic [COORD_BITS-1:0] new_val;

   assign req_acc    = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign j_last     = (CFG_BITS'(j_ff) + 1'b1) == duse_ff;
   assign k_last     = (CFG_BITS'(k_ff) + 1'b1) == kuse_ff;
   assign p_last     = (PCW'(p_ff) + 1'b1) == npts_ff;
   assign pipe_empty = !s1_ff.vld && !s2_ff.vld && !s3_ff.vld;
   assign count_k    = count_ff[k_ff];
   assign dcur       = clamp_sel(vdim_ff);
   assign dsum       = {1'b0, dist_ff} + {1'b0, prod_ff};
   assign dsat       = dsum[DIST_BITS] ? '1 : dsum[DIST_BITS-1:0];
   assign sum_cur    = sumv_ff[caddr_ff] ? sum_rd_ff : '0;
   assign sum_mag    = sum_cur[SUMW-1] ? (~sum_cur + 1'b1) : sum_cur;
   assign pt_ext     = {{(SUMW-COORD_BITS){pt_rd_ff[COORD_BITS-1]}}, pt_rd_ff};
   assign dtry       = {drem_ff[PCW-1:0], dquo_ff[SUMW-1]};
   assign dge        = dtry >= {1'b0, count_k};
   assign new_val    = dneg_ff ? (~dquo_ff[COORD_BITS-1:0] + 1'b1) : dquo_ff[COORD_BITS-1:0];
   assign pt_raddr   = {p_ff, j_ff};
   assign sum_raddr  = (state_ff == ST_ACC_ISSUE) ? (sbase_ff + CADDR_BITS'(j_ff)) : caddr_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.cmd == CMD_START)
               state_in = (maxit_ff == '0) ? ST_OUT_RD : ST_ITER_INIT;
         end
         ST_ITER_INIT: state_in = (npts_ff == '0) ? ST_UPD_INIT : ST_ASN_ISSUE;
         ST_ASN_ISSUE: if (j_last && k_last) state_in = ST_ASN_DRAIN;
         ST_ASN_DRAIN: if (pipe_empty) state_in = ST_ACC_ISSUE;
         ST_ACC_ISSUE: if (j_last) state_in = p_last ? ST_UPD_INIT : ST_ASN_ISSUE;
         ST_UPD_INIT:  state_in = ST_UPD_RD;
         ST_UPD_RD: begin
            if (count_k != '0) state_in = ST_UPD_LOAD;
            else if (k_last)   state_in = ST_UPD_DRAIN;
         end
         ST_UPD_LOAD:  state_in = ST_UPD_DIV;
         ST_UPD_DIV:   if (dcnt_ff == DCW'(SUMW - 1)) state_in = ST_UPD_WR;
         ST_UPD_WR:    state_in = (j_last && k_last) ? ST_UPD_DRAIN : ST_UPD_RD;
         ST_UPD_DRAIN: if (pipe_empty) state_in = ST_ITER_END;
         ST_ITER_END: begin
            if (conv_ok_ff || (iter_ff + 1'b1) == maxit_ff) state_in = ST_OUT_RD;
            else                                            state_in = ST_ITER_INIT;
         end
         ST_OUT_RD:    state_in = ST_OUT_CAP;
         ST_OUT_CAP: begin
            if (out_free) state_in = (j_last && k_last) ? ST_IDLE : ST_OUT_RD;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // actions and datapath
   always_comb begin
      npts_in      = npts_ff;
      ppos_in      = ppos_ff;
      cload_in     = cload_ff;
      kuse_in      = kuse_ff;
      duse_in      = duse_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      caddr_in     = caddr_ff;
      sbase_in     = sbase_ff;
      iter_in      = iter_ff;
      conv_ok_in   = conv_ok_ff;
      conv_out_in  = conv_out_ff;
      sumv_in      = sumv_ff;
      count_in     = count_ff;
      dcnt_in      = dcnt_ff;
      old_in       = old_ff;
      dist_in      = dist_ff;
      bestd_in     = bestd_ff;
      bestk_in     = bestk_ff;
      drem_in      = drem_ff;
      dquo_in      = dquo_ff;
      dneg_in      = dneg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      s1_in        = '0;
      ac_vld_in    = (state_ff == ST_ACC_ISSUE);
      ac_addr_in   = sum_raddr;
      pt_we        = 1'b0;
      pt_waddr     = {npts_ff[PW-1:0], ppos_ff};
      pt_wdata     = req_data.coord_value;
      cent_we      = 1'b0;
      cent_waddr   = cload_ff[CADDR_BITS-1:0];
      cent_wdata   = req_data.coord_value;
      sum_we       = ac_vld_ff;
      sum_waddr    = ac_addr_ff;
      sum_wdata    = (sumv_ff[ac_addr_ff] ? sum_rd_ff : '0) + pt_ext;
      if (ac_vld_ff) sumv_in[ac_addr_ff] = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_data.cmd)
                  CMD_LOAD_POINT: begin
                     if (npts_ff < PCW'(MAX_POINTS)) begin
                        pt_we = 1'b1;
                        if ((CFG_BITS'(ppos_ff) + 1'b1) >= dcur) begin
                           ppos_in = '0;
                           npts_in = npts_ff + 1'b1;
                        end else begin
                           ppos_in = ppos_ff + 1'b1;
                        end
                     end
                  end
                  CMD_LOAD_CENTROID: begin
                     if (cload_ff < CLOAD_BITS'(CSLOTS)) begin
                        cent_we  = 1'b1;
                        cload_in = cload_ff + 1'b1;
                     end
                  end
                  CMD_START: begin
                     kuse_in     = clamp_sel(ncl_ff);
                     duse_in     = dcur;
                     iter_in     = '0;
                     conv_out_in = 1'b0;
                     k_in        = '0;
                     j_in        = '0;
                     caddr_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_ITER_INIT: begin
            sumv_in    = '0;
            for (int i = 0; i < MAX_CLUSTERS; i++) count_in[i] = '0;
            p_in       = '0;
            k_in       = '0;
            j_in       = '0;
            caddr_in   = '0;
            conv_ok_in = 1'b1;
            dist_in    = '0;
            bestd_in   = '1;
            bestk_in   = '0;
         end
         ST_ASN_ISSUE: begin
            s1_in    = '{vld: 1'b1, last: j_last, upd: 1'b0, kidx: k_ff};
            caddr_in = caddr_ff + 1'b1;
            if (j_last) begin
               j_in = '0;
               k_in = k_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_ASN_DRAIN: begin
            if (pipe_empty) begin
               count_in[bestk_ff] = count_ff[bestk_ff] + 1'b1;
               sbase_in = {3'b0, bestk_ff} * {2'b0, duse_ff};
               j_in     = '0;
            end
         end
         ST_ACC_ISSUE: begin
            if (j_last) begin
               j_in     = '0;
               k_in     = '0;
               caddr_in = '0;
               p_in     = p_ff + 1'b1;
               bestd_in = '1;
               bestk_in = '0;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_UPD_INIT: begin
            k_in     = '0;
            j_in     = '0;
            caddr_in = '0;
         end
         ST_UPD_RD: begin
            // empty cluster keeps its centroid and moves by nothing
            if (count_k == '0) begin
               if (eps_ff == '0) conv_ok_in = 1'b0;
               caddr_in = caddr_ff + CADDR_BITS'(duse_ff);
               k_in     = k_ff + 1'b1;
            end
         end
         ST_UPD_LOAD: begin
            dquo_in = sum_mag + SUMW'(count_k >> 1);
            dneg_in = sum_cur[SUMW-1];
            drem_in = '0;
            dcnt_in = '0;
            old_in  = ct_rd_ff;
         end
         ST_UPD_DIV: begin
            drem_in = dge ? (dtry - {1'b0, count_k}) : dtry;
            dquo_in = {dquo_ff[SUMW-2:0], dge};
            dcnt_in = dcnt_ff + 1'b1;
         end
         ST_UPD_WR: begin
            cent_we    = 1'b1;
            cent_waddr = caddr_ff;
            cent_wdata = new_val;
            caddr_in   = caddr_ff + 1'b1;
            if (j_last) begin
               j_in = '0;
               k_in = k_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_UPD_DRAIN: ;
         ST_ITER_END: begin
            iter_in     = iter_ff + 1'b1;
            conv_out_in = conv_ok_ff;
            k_in        = '0;
            j_in        = '0;
            caddr_in    = '0;
         end
         ST_OUT_RD: ;
         ST_OUT_CAP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{cluster_index: k_ff, coord_index: j_ff,
                                centroid_value: ct_rd_ff, converged: conv_out_ff,
                                iterations_done: iter_ff, last: j_last && k_last};
               caddr_in     = caddr_ff + 1'b1;
               if (j_last) begin
                  j_in = '0;
                  k_in = k_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
               if (j_last && k_last) cload_in = '0;
            end
         end
         default: ;
      endcase

      // distance pipeline: abs diff, square, saturating sum
      if (state_ff == ST_UPD_WR) begin
         absd_in = abs_diff(new_val, old_ff);
         s2_in   = '{vld: 1'b1, last: j_last, upd: 1'b1, kidx: k_ff};
      end else begin
         absd_in = abs_diff(pt_rd_ff, ct_rd_ff);
         s2_in   = s1_ff;
      end
      prod_in = {32'b0, absd_ff} * {32'b0, absd_ff};
      s3_in   = s2_ff;
      if (s3_ff.vld) begin
         if (s3_ff.last) begin
            dist_in = '0;
            if (s3_ff.upd) begin
               if (dsat >= {1'b0, eps_ff}) conv_ok_in = 1'b0;
            end else if (dsat <= bestd_ff) begin
               // later index wins a tie
               bestd_in = dsat;
               bestk_in = s3_ff.kidx;
            end
         end else begin
            dist_in = dsat;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ncl_ff       <= CFG_BITS'(2);
         vdim_ff      <= CFG_BITS'(2);
         maxit_ff     <= ITER_BITS'(300);
         eps_ff       <= '0;
         npts_ff      <= '0;
         ppos_ff      <= '0;
         cload_ff     <= '0;
         iter_ff      <= '0;
         conv_ok_ff   <= 1'b0;
         conv_out_ff  <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         ac_vld_ff    <= 1'b0;
         sumv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CLUSTERS; i++) count_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         npts_ff      <= npts_in;
         ppos_ff      <= ppos_in;
         cload_ff     <= cload_in;
         iter_ff      <= iter_in;
         conv_ok_ff   <= conv_ok_in;
         conv_out_ff  <= conv_out_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         ac_vld_ff    <= ac_vld_in;
         sumv_ff      <= sumv_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_NUM_CLUSTERS:   ncl_ff   <= csr_wdata[CFG_BITS-1:0];
               CSR_VECTOR_DIM:     vdim_ff  <= csr_wdata[CFG_BITS-1:0];
               CSR_MAX_ITERATIONS: maxit_ff <= csr_wdata[ITER_BITS-1:0];
               CSR_EPSILON_SQ:     eps_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kuse_ff     <= kuse_in;
      duse_ff     <= duse_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      caddr_ff    <= caddr_in;
      sbase_ff    <= sbase_in;
      ac_addr_ff  <= ac_addr_in;
      dcnt_ff     <= dcnt_in;
      old_ff      <= old_in;
      absd_ff     <= absd_in;
      prod_ff     <= prod_in;
      dist_ff     <= dist_in;
      bestd_ff    <= bestd_in;
      bestk_ff    <= bestk_in;
      drem_ff     <= drem_in;
      dquo_ff     <= dquo_in;
      dneg_ff     <= dneg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (pt_we) point_mem[pt_waddr] <= pt_wdata;
      pt_rd_ff <= point_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cent_we) cent_mem[cent_waddr] <= cent_wdata;
      ct_rd_ff <= cent_mem[caddr_ff];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   // checks
   a_iter_end_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER_END) |-> (pipe_empty && !ac_vld_ff))
      else $error("distance pipeline busy at iteration end");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER_END) |-> (iter_ff < maxit_ff))
      else $error("iteration count passed its limit");

   a_div_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_DIV) |-> (!s1_ff.vld && !ac_vld_ff))
      else $error("assignment traffic during centroid division");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_CAP && out_free && j_last && k_last) |=>
      (rsp_valid_ff && rsp_data_ff.last && state_ff == ST_IDLE))
      else $error("final word not flagged last");

endmodule

`default_nettype wire

/* tb/sv/kmeans_clustering_engine_test.sv */
// ---------------------------------------------------------------------------
// kmeans_clustering_engine_test
// Self-checking bench for the k-means engine. Points and centroids are loaded
// word by word, start words run Lloyd iterations, and every returned centroid
// coordinate is compared with a bit-exact predictor held in a scoreboard.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import kce_pkg::*;

class kmeans_scoreboard;
   localparam int NPTS = 1024;

   longint          point_coord[NPTS*MAX_DIM];
   longint          centroid[CSLOTS];
   longint          prev_centroid[CSLOTS];
   bit [63:0]       coord_sum[CSLOTS];
   int unsigned     members[MAX_CLUSTERS];
   int unsigned     n_points, n_cent_loads, coord_pos;
   bit [3:0]        reg_k, reg_d;
   bit [15:0]       reg_iter;
   bit [62:0]       reg_eps;
   rsp_type         pending[$];
   int              errors;

   function new();
      reg_k = 2;
      reg_d = 2;
      reg_iter = 300;
      reg_eps = '0;
      n_points = 0;
      n_cent_loads = 0;
      coord_pos = 0;
      errors = 0;
      foreach (centroid[i]) centroid[i] = 0;
      foreach (point_coord[i]) point_coord[i] = 0;
   endfunction

   function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [EPS_BITS-1:0] v);
      case (idx)
         CSR_NUM_CLUSTERS:   reg_k = v[3:0];
         CSR_VECTOR_DIM:     reg_d = v[3:0];
         CSR_MAX_ITERATIONS: reg_iter = v[15:0];
         CSR_EPSILON_SQ:     reg_eps = v;
         default: ;
      endcase
   endfunction

   function int unsigned clamp_sel(bit [3:0] v);
      if (v == 0) return 1;
      return (v > 8) ? 8 : v;
   endfunction

   function bit [63:0] sq_diff(longint a, longint b);
      longint    d;
      bit [63:0] m;
      d = a - b;
      m = (d < 0) ? -d : d;
      if (m >= 64'h1_0000_0000) return '1;
      return m * m;
   endfunction

   function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
      bit [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // sum over count, halves away from zero
   function longint round_mean(bit [63:0] s, int unsigned c);
      bit [63:0] mag, q;
      mag = s[63] ? (~s + 64'd1) : s;
      q = (mag + 64'(c / 2)) / 64'(c);
      return s[63] ? -longint'(q) : longint'(q);
   endfunction

   function void lloyd(int unsigned kk, int unsigned dd);
      int unsigned iters, best;
      bit          conv;
      bit [63:0]   dsq, bestd, mv;
      rsp_type     r;
      iters = 0;
      conv = 0;
      prev_centroid = centroid;
      while (iters < reg_iter) begin
         foreach (coord_sum[i]) coord_sum[i] = '0;
         foreach (members[i]) members[i] = 0;
         for (int p = 0; p < n_points; p++) begin
            best = 0;
            bestd = '1;
            for (int k = 0; k < kk; k++) begin
               dsq = '0;
               for (int j = 0; j < dd; j++)
                  dsq = sat_add(dsq, sq_diff(point_coord[p*MAX_DIM+j], centroid[k*dd+j]));
               if (dsq <= bestd) begin
                  bestd = dsq;
                  best = k;
               end
            end
            members[best]++;
            for (int j = 0; j < dd; j++)
               coord_sum[best*dd+j] += 64'(point_coord[p*MAX_DIM+j]);
         end
         for (int k = 0; k < kk; k++)
            if (members[k] != 0)
               for (int j = 0; j < dd; j++)
                  centroid[k*dd+j] = round_mean(coord_sum[k*dd+j], members[k]);
         iters++;
         conv = 1;
         for (int k = 0; k < kk && conv; k++) begin
            mv = '0;
            for (int j = 0; j < dd; j++)
               mv = sat_add(mv, sq_diff(centroid[k*dd+j], prev_centroid[k*dd+j]));
            if (mv >= {1'b0, reg_eps}) conv = 0;
         end
         if (conv) break;
         prev_centroid = centroid;
      end
      n_cent_loads = 0;
      for (int k = 0; k < kk; k++)
         for (int j = 0; j < dd; j++) begin
            r.cluster_index = k[2:0];
            r.coord_index = j[2:0];
            r.centroid_value = centroid[k*dd+j][31:0];
            r.converged = conv;
            r.iterations_done = iters[15:0];
            r.last = (k + 1 == kk) && (j + 1 == dd);
            pending.push_back(r);
         end
   endfunction

   function void note_input(req_type w);
      int unsigned kk, dd;
      longint      v;
      kk = clamp_sel(reg_k);
      dd = clamp_sel(reg_d);
      v = longint'(w.coord_value);
      case (w.cmd)
         CMD_LOAD_POINT: begin
            if (n_points < NPTS) begin
               point_coord[n_points*MAX_DIM+coord_pos] = v;
               if (coord_pos + 1 >= dd) begin
                  coord_pos = 0;
                  n_points++;
               end else begin
                  coord_pos++;
               end
            end
         end
         CMD_LOAD_CENTROID: begin
            if (n_cent_loads < CSLOTS) begin
               centroid[n_cent_loads] = v;
               n_cent_loads++;
            end
         end
         CMD_START: lloyd(kk, dd);
         default: ;
      endcase
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         $error("unexpected result word %h", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.cluster_index !== want.cluster_index) begin
         $error("cluster_index: expected %0d, got %0d", want.cluster_index, got.cluster_index);
         errors++;
      end
      if (got.coord_index !== want.coord_index) begin
         $error("coord_index: expected %0d, got %0d", want.coord_index, got.coord_index);
         errors++;
      end
      if (got.centroid_value !== want.centroid_value) begin
         $error("centroid_value: expected %h, got %h", want.centroid_value,
                got.centroid_value);
         errors++;
      end
      if (got.converged !== want.converged) begin
         $error("converged: expected %0d, got %0d", want.converged, got.converged);
         errors++;
      end
      if (got.iterations_done !== want.iterations_done) begin
         $error("iterations_done: expected %0d, got %0d", want.iterations_done,
                got.iterations_done);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         errors++;
      end
   endfunction
endclass

module kmeans_clustering_engine_test;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_NUM_CLUSTERS;
   logic [EPS_BITS-1:0]     csr_wdata = '0;

   kmeans_scoreboard sb;
   bit               tx_burst;
   int               rand_words;
   int               rsp_count;
   int unsigned      d_cur, c_written;

   kmeans_clustering_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #30ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
   endfunction

   task automatic send_word(logic [1:0] cmd, logic [31:0] val);
      req_type     w;
      int unsigned gap;
      w.cmd = cmd;
      w.coord_value = val;
      gap = tx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(w);
      rand_words++;
   endtask

   task automatic write_regs(logic [3:0] k, logic [3:0] d, logic [15:0] it,
                             logic [EPS_BITS-1:0] eps);
      logic [CSR_IDX_BITS-1:0] idx[4];
      logic [EPS_BITS-1:0]     val[4];
      idx = '{CSR_NUM_CLUSTERS, CSR_VECTOR_DIM, CSR_MAX_ITERATIONS, CSR_EPSILON_SQ};
      val = '{EPS_BITS'(k), EPS_BITS'(d), EPS_BITS'(it), eps};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.set_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
      tx_burst = ($urandom_range(0, 3) == 0);
   endtask

   task automatic load_points(int n, int unsigned dd);
      for (int p = 0; p < n; p++)
         for (int j = 0; j < dd; j++) begin
            if ($urandom_range(0, 9) == 0) send_word(CMD_RESERVED, $urandom);
            send_word(CMD_LOAD_POINT, rand_coord());
         end
   endtask

   task automatic load_centroids(int n);
      for (int i = 0; i < n; i++) send_word(CMD_LOAD_CENTROID, rand_coord());
      if (n > c_written) c_written = n;
   endtask

   // wait for every expected word, then let the engine go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result side: random stalls, quiet stretches, one long hold-off
   initial begin
      int unsigned gap;
      bit          rx_burst;
      rsp_count = 0;
      rx_burst = 0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (rsp_count % 16 == 0) rx_burst = ($urandom_range(0, 2) == 0);
         gap = (rsp_count == 10) ? 500 : (rx_burst ? 0 : $urandom_range(0, 11));
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(rsp_data);
         rsp_count++;
      end
   end

   initial begin
      int unsigned kk, dd, np;
      logic [3:0]  raw_k, raw_d;
      logic [62:0] eps;
      sb = new();
      tx_burst = 0;
      c_written = 0;
      rand_words = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, no points loaded: centroids stay put
      for (int i = 0; i < 4; i++) send_word(CMD_LOAD_CENTROID, 32'(i) << 16);
      c_written = 4;
      send_word(CMD_START, '0);
      settle();

      // widest shape, extreme points, repeated centroids for ties, two starts
      write_regs(4'd8, 4'd8, 16'd3, '0);
      for (int j = 0; j < 8; j++) send_word(CMD_LOAD_POINT, 32'h7fff_ffff);
      for (int j = 0; j < 8; j++) send_word(CMD_LOAD_POINT, 32'h8000_0000);
      for (int j = 0; j < 8; j++) send_word(CMD_LOAD_POINT, 32'h0000_0000);
      for (int i = 0; i < 64; i++) send_word(CMD_LOAD_CENTROID, 32'((i / 16) << 18));
      c_written = 64;
      send_word(CMD_START, 32'hffff_ffff);
      send_word(CMD_START, '0);
      settle();

      // zero limits: cluster count acts as one, dimension clamps, no iterations
      write_regs(4'd0, 4'd15, 16'd0, '0);
      for (int i = 0; i < 8; i++) send_word(CMD_LOAD_CENTROID, rand_coord());
      send_word(CMD_RESERVED, 32'h5a5a_a5a5);
      send_word(CMD_START, '0);
      settle();

      // largest iteration limit; huge epsilon stops the run early
      write_regs(4'd5, 4'd4, 16'hffff, {EPS_BITS{1'b1}});
      load_points(2, 4);
      load_centroids(20);
      send_word(CMD_START, '0);
      settle();
      d_cur = 4;

      // random runs top the total up to about 150 words
      while (rand_words < 150) begin
         dd = $urandom_range(1, d_cur);
         d_cur = dd;
         kk = $urandom_range(1, 8);
         raw_k = 4'(kk);
         raw_d = 4'(dd);
         if (kk == 1 && $urandom_range(0, 1)) raw_k = 0;
         if (kk == 8 && $urandom_range(0, 1)) raw_k = 4'($urandom_range(9, 15));
         if (dd == 1 && $urandom_range(0, 1)) raw_d = 0;
         case ($urandom_range(0, 3))
            0: eps = '0;
            1: eps = 63'({$urandom, $urandom});
            default: eps = 63'($urandom_range(0, 32'h00ff_ffff));
         endcase
         write_regs(raw_k, raw_d, 16'($urandom_range(1, 6)), eps);
         np = $urandom_range(0, 4);
         load_points(np, dd);
         if (kk * dd > c_written || $urandom_range(0, 3) != 0)
            load_centroids(kk * dd + $urandom_range(0, 3));
         send_word(CMD_START, $urandom);
         if ($urandom_range(0, 3) == 0) send_word(CMD_START, $urandom);
         settle();
      end

      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/kce_pkg.sv
hw/rtl/kmeans_clustering_engine.sv
tb/sv/kmeans_clustering_engine_test.sv
